FILE: hdl/wts_pkg.sv
`default_nettype none

package wts_pkg;

    localparam int RAM_BYTES = 2048;
    localparam int RAM_AW    = 11;
    localparam int PHASE_W   = 24;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;

    localparam logic REG_ENABLED = 1'b0;
    localparam logic REG_VOLUME  = 1'b1;

    localparam logic [15:0] PAGE_REG_ADDR  = 16'hFCFF;
    localparam logic [7:0]  PAGE_WINDOW_HI = 8'hFD;
    localparam logic [3:0]  PAGE_OPEN_CODE = 4'h3;

    localparam logic [2:0] REG_AREA_HI = 3'b111;

    localparam logic [2:0] FLD_FLO  = 3'd0;
    localparam logic [2:0] FLD_FMED = 3'd1;
    localparam logic [2:0] FLD_FHI  = 3'd2;
    localparam logic [2:0] FLD_WAVE = 3'd5;
    localparam logic [2:0] FLD_AMP  = 3'd6;
    localparam logic [2:0] FLD_CTRL = 3'd7;

    localparam logic [2:0] STEP_FLO    = 3'd0;
    localparam logic [2:0] STEP_FMED   = 3'd1;
    localparam logic [2:0] STEP_FHI    = 3'd2;
    localparam logic [2:0] STEP_WAVE   = 3'd3;
    localparam logic [2:0] STEP_AMP    = 3'd4;
    localparam logic [2:0] STEP_CTRL   = 3'd5;
    localparam logic [2:0] STEP_SAMPLE = 3'd6;
    localparam logic [2:0] STEP_MIX    = 3'd7;

    localparam logic [7:0]  AMP_MAX    = 8'h80;
    localparam logic [6:0]  VOLUME_RST = 7'd100;
    localparam logic [24:0] DIV100_MUL = 25'd21474837;

    localparam logic [6:0] PAN_LEFT [16] = '{
        7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
        7'd100, 7'd100, 7'd100, 7'd83, 7'd67, 7'd50, 7'd33, 7'd17
    };
    localparam logic [6:0] PAN_RIGHT [16] = '{
        7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100,
        7'd0, 7'd0, 7'd0, 7'd17, 7'd33, 7'd50, 7'd67, 7'd83
    };
    localparam logic [12:0] SEG_BASE [8] = '{
        13'd0, 13'd33, 13'd99, 13'd231, 13'd495, 13'd1023, 13'd2079, 13'd4191
    };

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_TICK,
        ST_SEG,
        ST_PAN,
        ST_DIVL,
        ST_DIVR,
        ST_ACCR,
        ST_VOL,
        ST_VDIVL,
        ST_VDIVR,
        ST_FRAME
    } wts_state_t;

    function automatic logic [12:0] d2a(input logic [6:0] d);
        logic [3:0] sh;
        sh = {1'b0, d[6:4]} + 4'd1;
        return SEG_BASE[d[6:4]] + (13'(d[3:0]) << sh);
    endfunction

    function automatic logic [17:0] div100(input logic [23:0] m);
        logic [48:0] p;
        p = 49'(m) * 49'(DIV100_MUL);
        return p[48:31];
    endfunction

    function automatic logic signed [18:0] apply_sign(input logic [17:0] q,
                                                      input logic neg);
        logic signed [18:0] v;
        v = $signed({1'b0, q});
        return neg ? -v : v;
    endfunction

    function automatic logic [15:0] sat16(input logic signed [18:0] v);
        logic [15:0] r;
        if (v > 19'sd32767)
        begin
            r = 16'h7FFF;
        end
        else if (v < -19'sd32768)
        begin
            r = 16'h8000;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/wavetable_synth_16ch.sv
// Bus write: the word is taken in idle, no word out. Bus read: the RAM byte is registered
// first, then the reply word once the output is free.
// Tick: each channel slot does eight RAM reads on the single wave RAM port, then mixing;
// the slot that ends a frame adds volume scaling and saturation (ST_VOL to ST_FRAME).
// A new word is accepted while a finished reply or frame still waits at the output.
// Reset is asynchronous active low; afterwards a clearing pass zeroes the 2048-byte RAM,
// during which no word is accepted (configuration writes are taken).
`default_nettype none

module wavetable_synth_16ch #(
    parameter int CHANNELS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  action,
    input  wire logic [15:0] address,
    input  wire logic [7:0]  write_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             result_kind,
    output logic      [7:0]  read_data,
    output logic             read_hit,
    output logic      [15:0] left_sample,
    output logic      [15:0] right_sample
);
    import wts_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

    wts_state_t state_reg, state_next;
    logic [2:0]          step_reg, step_next;
    logic [RAM_AW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic                enabled_reg, enabled_next;
    logic [6:0]          volume_reg, volume_next;
    logic [7:0]          page_reg, page_next;
    logic [CH_W-1:0]     chan_reg, chan_next;
    logic                alt_reg, alt_next;
    logic signed [17:0]  left_sum_reg, left_sum_next;
    logic signed [17:0]  right_sum_reg, right_sum_next;
    logic [PHASE_W-1:0]  phase_reg [CHANNELS];
    logic [PHASE_W-1:0]  phase_wdata;
    logic                phase_we;
    logic [7:0]          flo_reg, flo_next;
    logic [7:0]          fmed_reg, fmed_next;
    logic [7:0]          wave_reg, wave_next;
    logic [7:0]          amp_reg, amp_next;
    logic [7:0]          ctrl_reg, ctrl_next;
    logic                carry_reg, carry_next;
    logic [6:0]          mag_reg, mag_next;
    logic                neg_reg, neg_next;
    logic [12:0]         smp_reg, smp_next;
    logic [23:0]         prod_l_reg, prod_l_next;
    logic [23:0]         prod_r_reg, prod_r_next;
    logic                neg_l_reg, neg_l_next;
    logic                neg_r_reg, neg_r_next;
    logic [17:0]         quo_reg, quo_next;
    logic [15:0]         lsamp_reg, lsamp_next;
    logic                rd_hit_reg, rd_hit_next;
    logic                rd_page_reg, rd_page_next;
    logic                out_valid_reg, out_valid_next;
    logic                kind_reg, kind_next;
    logic [7:0]          rdata_out_reg, rdata_out_next;
    logic                hit_out_reg, hit_out_next;
    logic [15:0]         lout_reg, lout_next;
    logic [15:0]         rout_reg, rout_next;

    logic [7:0]          wave_mem [RAM_BYTES];
    logic [7:0]          ram_rdata_reg;
    logic [RAM_AW-1:0]   ram_addr;
    logic [7:0]          ram_wdata;
    logic                ram_we;
    logic                ram_re;

    logic                out_free;
    logic                page_open;
    logic                is_page_addr;
    logic                in_window;
    logic                cfg_write;
    logic [3:0]          ch4;
    logic [PHASE_W-1:0]  phase_cur;
    logic [PHASE_W:0]    phase_sum;
    logic [7:0]          amp_clamp;
    logic [14:0]         amp_prod;
    logic [23:0]         div_in;
    logic [17:0]         lmag;
    logic [17:0]         rmag;

    assign pready       = 1'b1;
    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign result_kind  = kind_reg;
    assign read_data    = rdata_out_reg;
    assign read_hit     = hit_out_reg;
    assign left_sample  = lout_reg;
    assign right_sample = rout_reg;

    assign out_free     = !out_valid_reg || out_ready;
    assign page_open    = (page_reg[7:4] == PAGE_OPEN_CODE);
    assign is_page_addr = (address == PAGE_REG_ADDR);
    assign in_window    = (address[15:8] == PAGE_WINDOW_HI);
    assign cfg_write    = psel && penable && pwrite && pready;
    assign ch4          = 4'(chan_reg);
    assign phase_cur    = phase_reg[chan_reg];
    assign amp_clamp    = (amp_reg > AMP_MAX) ? AMP_MAX : amp_reg;
    assign amp_prod     = 15'(ram_rdata_reg[6:0]) * 15'(amp_clamp);
    assign lmag         = left_sum_reg[17] ? 18'(-left_sum_reg) : 18'(left_sum_reg);
    assign rmag         = right_sum_reg[17] ? 18'(-right_sum_reg) : 18'(right_sum_reg);
    assign div_in       = (state_reg == ST_DIVL || state_reg == ST_VDIVL) ?
                          prod_l_reg : prod_r_reg;

    always_comb
    begin
        prdata = 32'd0;
        if (paddr[2] == REG_VOLUME)
        begin
            prdata = {25'd0, volume_reg};
        end
        else
        begin
            prdata = {31'd0, enabled_reg};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid && action == ACT_READ)
                begin
                    state_next = ST_READ;
                end
                else if (in_valid && action == ACT_TICK)
                begin
                    state_next = ST_TICK;
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_TICK:
            begin
                if (step_reg == STEP_MIX)
                begin
                    state_next = ST_SEG;
                end
            end
            ST_SEG:   state_next = ST_PAN;
            ST_PAN:   state_next = ST_DIVL;
            ST_DIVL:  state_next = ST_DIVR;
            ST_DIVR:  state_next = ST_ACCR;
            ST_ACCR:  state_next = (chan_reg == LAST_CH) ? ST_VOL : ST_IDLE;
            ST_VOL:   state_next = ST_VDIVL;
            ST_VDIVL: state_next = ST_VDIVR;
            ST_VDIVR: state_next = ST_FRAME;
            ST_FRAME:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        step_next      = step_reg;
        clr_cnt_next   = clr_cnt_reg;
        enabled_next   = enabled_reg;
        volume_next    = volume_reg;
        page_next      = page_reg;
        chan_next      = chan_reg;
        alt_next       = alt_reg;
        left_sum_next  = left_sum_reg;
        right_sum_next = right_sum_reg;
        phase_we       = 1'b0;
        phase_wdata    = '0;
        phase_sum      = {1'b0, phase_cur} +
                         {1'b0, ram_rdata_reg, fmed_reg, flo_reg[7:1], 1'b0};
        flo_next       = flo_reg;
        fmed_next      = fmed_reg;
        wave_next      = wave_reg;
        amp_next       = amp_reg;
        ctrl_next      = ctrl_reg;
        carry_next     = carry_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        smp_next       = smp_reg;
        prod_l_next    = prod_l_reg;
        prod_r_next    = prod_r_reg;
        neg_l_next     = neg_l_reg;
        neg_r_next     = neg_r_reg;
        quo_next       = div100(div_in);
        lsamp_next     = lsamp_reg;
        rd_hit_next    = rd_hit_reg;
        rd_page_next   = rd_page_reg;
        out_valid_next = out_valid_reg && !out_ready;
        kind_next      = kind_reg;
        rdata_out_next = rdata_out_reg;
        hit_out_next   = hit_out_reg;
        lout_next      = lout_reg;
        rout_next      = rout_reg;
        ram_addr       = '0;
        ram_wdata      = write_data;
        ram_we         = 1'b0;
        ram_re         = 1'b0;

        if (cfg_write)
        begin
            if (paddr[2] == REG_VOLUME)
            begin
                volume_next = pwdata[6:0];
            end
            else
            begin
                enabled_next = pwdata[0];
            end
        end

        case (state_reg)
            ST_CLEAR:
            begin
                ram_addr     = clr_cnt_reg;
                ram_wdata    = 8'd0;
                ram_we       = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            ST_IDLE:
            begin
                step_next = STEP_FLO;
                ram_addr  = {page_reg[3:1], address[7:0]};
                if (in_valid && action == ACT_WRITE && enabled_reg)
                begin
                    if (is_page_addr)
                    begin
                        page_next = write_data;
                    end
                    else if (page_open && in_window)
                    begin
                        ram_we = 1'b1;
                    end
                end
                if (in_valid && action == ACT_READ)
                begin
                    ram_re       = 1'b1;
                    rd_hit_next  = enabled_reg && page_open && (is_page_addr || in_window);
                    rd_page_next = is_page_addr;
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = 1'b0;
                    hit_out_next   = rd_hit_reg;
                    lout_next      = 16'd0;
                    rout_next      = 16'd0;
                    if (!rd_hit_reg)
                    begin
                        rdata_out_next = 8'd0;
                    end
                    else if (rd_page_reg)
                    begin
                        rdata_out_next = page_reg;
                    end
                    else
                    begin
                        rdata_out_next = ram_rdata_reg;
                    end
                end
            end
            ST_TICK:
            begin
                step_next = step_reg + 3'd1;
                ram_re    = 1'b1;
                case (step_reg)
                    STEP_FLO:    ram_addr = {REG_AREA_HI, alt_reg, FLD_FLO, ch4};
                    STEP_FMED:   ram_addr = {REG_AREA_HI, alt_reg, FLD_FMED, ch4};
                    STEP_FHI:    ram_addr = {REG_AREA_HI, alt_reg, FLD_FHI, ch4};
                    STEP_WAVE:   ram_addr = {REG_AREA_HI, alt_reg, FLD_WAVE, ch4};
                    STEP_AMP:    ram_addr = {REG_AREA_HI, alt_reg, FLD_AMP, ch4};
                    STEP_CTRL:   ram_addr = {REG_AREA_HI, alt_reg, FLD_CTRL, ch4};
                    STEP_SAMPLE: ram_addr = {wave_reg[7:4], phase_cur[23:17]};
                    default:     ram_addr = '0;
                endcase
                case (step_reg)
                    STEP_FMED:   flo_next  = ram_rdata_reg;
                    STEP_FHI:    fmed_next = ram_rdata_reg;
                    STEP_WAVE:
                    begin
                        phase_we = 1'b1;
                        if (flo_reg[0])
                        begin
                            phase_wdata = '0;
                            carry_next  = 1'b0;
                        end
                        else
                        begin
                            phase_wdata = phase_sum[PHASE_W-1:0];
                            carry_next  = phase_sum[PHASE_W];
                        end
                    end
                    STEP_AMP:    wave_next = ram_rdata_reg;
                    STEP_CTRL:   amp_next  = ram_rdata_reg;
                    STEP_SAMPLE: ctrl_next = ram_rdata_reg;
                    STEP_MIX:
                    begin
                        mag_next = amp_prod[13:7];
                        neg_next = ram_rdata_reg[7] ^ ctrl_reg[4];
                        alt_next = ctrl_reg[5] && (ram_rdata_reg[7] || carry_reg);
                    end
                    default:
                    begin
                        flo_next = flo_reg;
                    end
                endcase
            end
            ST_SEG:
            begin
                smp_next = d2a(mag_reg);
            end
            ST_PAN:
            begin
                prod_l_next = 24'(smp_reg) * 24'(PAN_LEFT[ctrl_reg[3:0]]);
                prod_r_next = 24'(smp_reg) * 24'(PAN_RIGHT[ctrl_reg[3:0]]);
                neg_l_next  = neg_reg;
                neg_r_next  = neg_reg;
            end
            ST_DIVR:
            begin
                left_sum_next = 18'(19'(left_sum_reg) + apply_sign(quo_reg, neg_l_reg));
            end
            ST_ACCR:
            begin
                right_sum_next = 18'(19'(right_sum_reg) + apply_sign(quo_reg, neg_r_reg));
                if (chan_reg != LAST_CH)
                begin
                    chan_next = chan_reg + 1'b1;
                end
            end
            ST_VOL:
            begin
                prod_l_next = 24'(lmag) * 24'(volume_reg);
                prod_r_next = 24'(rmag) * 24'(volume_reg);
                neg_l_next  = left_sum_reg[17];
                neg_r_next  = right_sum_reg[17];
            end
            ST_VDIVR:
            begin
                lsamp_next = sat16(apply_sign(quo_reg, neg_l_reg));
            end
            ST_FRAME:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = 1'b1;
                    rdata_out_next = 8'd0;
                    hit_out_next   = 1'b0;
                    lout_next      = lsamp_reg;
                    rout_next      = sat16(apply_sign(quo_reg, neg_r_reg));
                    left_sum_next  = '0;
                    right_sum_next = '0;
                    chan_next      = '0;
                    alt_next       = 1'b0;
                end
            end
            default:
            begin
                step_next = step_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ram_we)
        begin
            wave_mem[ram_addr] <= ram_wdata;
        end
        if (ram_re)
        begin
            ram_rdata_reg <= wave_mem[ram_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                phase_reg[i] <= '0;
            end
        end
        else if (phase_we)
        begin
            phase_reg[chan_reg] <= phase_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            step_reg      <= STEP_FLO;
            clr_cnt_reg   <= '0;
            enabled_reg   <= 1'b0;
            volume_reg    <= VOLUME_RST;
            page_reg      <= 8'd0;
            chan_reg      <= '0;
            alt_reg       <= 1'b0;
            left_sum_reg  <= '0;
            right_sum_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            clr_cnt_reg   <= clr_cnt_next;
            enabled_reg   <= enabled_next;
            volume_reg    <= volume_next;
            page_reg      <= page_next;
            chan_reg      <= chan_next;
            alt_reg       <= alt_next;
            left_sum_reg  <= left_sum_next;
            right_sum_reg <= right_sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        flo_reg       <= flo_next;
        fmed_reg      <= fmed_next;
        wave_reg      <= wave_next;
        amp_reg       <= amp_next;
        ctrl_reg      <= ctrl_next;
        carry_reg     <= carry_next;
        mag_reg       <= mag_next;
        neg_reg       <= neg_next;
        smp_reg       <= smp_next;
        prod_l_reg    <= prod_l_next;
        prod_r_reg    <= prod_r_next;
        neg_l_reg     <= neg_l_next;
        neg_r_reg     <= neg_r_next;
        quo_reg       <= quo_next;
        lsamp_reg     <= lsamp_next;
        rd_hit_reg    <= rd_hit_next;
        rd_page_reg   <= rd_page_next;
        kind_reg      <= kind_next;
        rdata_out_reg <= rdata_out_next;
        hit_out_reg   <= hit_out_next;
        lout_reg      <= lout_next;
        rout_reg      <= rout_next;
    end

endmodule

`default_nettype wire
